### rtl/dns_name_decompressor_top_defines.svh
// ----------------------------------------------------------------------------
// dns_name_decompressor_top_defines
// Assertion macros for the DNS name decompressor.
// ----------------------------------------------------------------------------
`ifndef DNS_NAME_DECOMPRESSOR_TOP_DEFINES_SVH
`define DNS_NAME_DECOMPRESSOR_TOP_DEFINES_SVH

// same-cycle implication
`define DNSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DNSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dnsd_pkg.sv
// ----------------------------------------------------------------------------
// dnsd_pkg
// Types and constants shared by the DNS name decompressor modules.
// ----------------------------------------------------------------------------
package dnsd_pkg;

  localparam int CHUNK_CHARS = 8;
  localparam int CHUNK_IDX_W = 3;
  localparam int MAX_RESULTS = 32;
  localparam int MAX_JUMPS   = 10;
  localparam int POS_W       = 15;

  localparam logic [7:0] PTR_MARK    = 8'hC0;
  localparam logic [7:0] PTR_HI_MASK = 8'h3F;
  localparam logic [7:0] DOT_CHAR    = 8'h2E;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef struct packed {
    logic        command;
    logic [11:0] byte_address;
    logic [7:0]  byte_value;
    logic [11:0] start_offset;
    logic [12:0] pkt_len;
  } dnsd_in_t;

  typedef struct packed {
    logic [63:0] chunk;
    logic [3:0]  chunk_len;
    logic        last_chunk;
    logic [12:0] next_offset;
    logic        name_truncated;
  } dnsd_out_t;

  typedef struct packed {
    logic init;
    logic advance;
    logic label_go;
    logic jump;
    logic put_chr;
    logic put_dot;
    logic emit_last;
  } dnsd_cmd_t;

  typedef struct packed {
    logic in_range;
    logic is_zero;
    logic is_ptr;
    logic ptr_cut;
    logic label_cut;
    logic jump_lim;
    logic rem_one;
  } dnsd_sts_t;

endpackage

### rtl/dnsd_store.sv
// ----------------------------------------------------------------------------
// dnsd_store
// Packet byte memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dnsd_store #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] wa_i,
  input  logic [7:0]        wd_i,
  input  logic [ADDR_W-1:0] ra_i,
  output logic [7:0]        rd_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wa_i] <= wd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[ra_i];
  end

  assign rd_o = rd_q;

endmodule

### rtl/dnsd_ctrl.sv
// ----------------------------------------------------------------------------
// dnsd_ctrl
// Label walk sequencer: header, pointer, character, dot and finish steps.
// ----------------------------------------------------------------------------
module dnsd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  dnsd_pkg::dnsd_sts_t sts_i,
  output dnsd_pkg::dnsd_cmd_t cmd_o,
  output logic                busy_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_PTR,
    S_CHAR,
    S_DOT,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (go_i) begin
          cmd_o.init = 1'b1;
          state_d    = S_HEAD;
          busy_d     = 1'b1;
        end
      end
      S_HEAD: begin
        priority if (!sts_i.in_range) begin
          state_d = S_DONE;
        end else if (sts_i.is_zero) begin
          cmd_o.advance = 1'b1;
          state_d       = S_DONE;
        end else if (sts_i.is_ptr) begin
          cmd_o.advance = 1'b1;
          state_d       = sts_i.ptr_cut ? S_DONE : S_PTR;
        end else if (sts_i.label_cut) begin
          cmd_o.advance = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.label_go = 1'b1;
          state_d        = S_CHAR;
        end
      end
      S_PTR: begin
        cmd_o.jump = 1'b1;
        state_d    = sts_i.jump_lim ? S_DONE : S_HEAD;
      end
      S_CHAR: begin
        cmd_o.put_chr = 1'b1;
        cmd_o.advance = 1'b1;
        if (sts_i.rem_one) begin
          state_d = S_DOT;
        end
      end
      S_DOT: begin
        cmd_o.put_dot = 1'b1;
        state_d       = S_HEAD;
      end
      S_DONE: begin
        cmd_o.emit_last = 1'b1;
        state_d         = S_IDLE;
        busy_d          = 1'b0;
      end
      default: begin
        state_d = S_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

### rtl/dnsd_dp.sv
// ----------------------------------------------------------------------------
// dnsd_dp
// Walk datapath: position, pointer bookkeeping, chunk assembly and result
// register.
// ----------------------------------------------------------------------------
module dnsd_dp #(
  parameter int PKT_BYTES      = 4096,
  parameter int MAX_NAME_CHARS = 255,
  parameter int ADDR_W         = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dnsd_pkg::dnsd_cmd_t cmd_i,
  output dnsd_pkg::dnsd_sts_t sts_o,
  input  logic [11:0]         start_offset_i,
  input  logic [12:0]         pkt_len_i,
  input  logic [7:0]          rd_data_i,
  output logic [ADDR_W-1:0]   rd_addr_o,
  output dnsd_pkg::dnsd_out_t res_o,
  output logic                res_valid_o
);

  localparam int PosW    = dnsd_pkg::POS_W;
  localparam int NameBuf = dnsd_pkg::MAX_RESULTS * dnsd_pkg::CHUNK_CHARS;
  localparam int NameCap = (MAX_NAME_CHARS < NameBuf) ? MAX_NAME_CHARS : NameBuf;
  localparam int CntW    = $clog2(NameCap + 1);

  logic [PosW-1:0] pos_q, pos_d, limit_q, limit_d, first_q, first_d;
  logic            jumped_q, jumped_d;
  logic [3:0]      jumps_q, jumps_d;
  logic [7:0]      rem_q, rem_d, hdr_q, hdr_d;
  logic [dnsd_pkg::CHUNK_CHARS-1:0][7:0] buf_q, buf_d;
  logic [3:0]      cnt_q, cnt_d;
  logic [CntW-1:0] name_q, name_d;
  logic            trunc_q, trunc_d;
  logic            valid_q, valid_d;
  dnsd_pkg::dnsd_out_t out_q, out_d;

  logic [PosW-1:0] pos_inc, label_end, tot_len, lim_sat, end_pos;
  logic [7:0]      hi_bits, ch;
  logic            put, keep, full;

  assign pos_inc   = pos_q + PosW'(1);
  assign label_end = pos_inc + PosW'(rd_data_i);
  assign tot_len   = PosW'(pkt_len_i);
  assign lim_sat   = (tot_len > PosW'(PKT_BYTES)) ? PosW'(PKT_BYTES) : tot_len;
  assign hi_bits   = hdr_q & dnsd_pkg::PTR_HI_MASK;
  assign end_pos   = jumped_q ? first_q : pos_q;

  always_comb begin
    sts_o.in_range  = pos_q < limit_q;
    sts_o.is_zero   = rd_data_i == 8'h00;
    sts_o.is_ptr    = (rd_data_i & dnsd_pkg::PTR_MARK) == dnsd_pkg::PTR_MARK;
    sts_o.ptr_cut   = pos_inc >= limit_q;
    sts_o.label_cut = label_end > limit_q;
    sts_o.jump_lim  = jumps_q >= 4'(dnsd_pkg::MAX_JUMPS);
    sts_o.rem_one   = rem_q == 8'd1;
  end

  always_comb begin
    pos_d    = pos_q;
    limit_d  = limit_q;
    first_d  = first_q;
    jumped_d = jumped_q;
    jumps_d  = jumps_q;
    rem_d    = rem_q;
    hdr_d    = hdr_q;
    if (cmd_i.init) begin
      pos_d    = PosW'(start_offset_i);
      limit_d  = lim_sat;
      jumped_d = 1'b0;
      jumps_d  = '0;
    end
    if (cmd_i.advance || cmd_i.label_go) begin
      pos_d = pos_inc;
      hdr_d = rd_data_i;
    end
    if (cmd_i.label_go) begin
      rem_d = rd_data_i;
    end
    if (cmd_i.put_chr) begin
      rem_d = rem_q - 8'd1;
    end
    if (cmd_i.jump) begin
      pos_d   = PosW'({hi_bits[5:0], rd_data_i});
      jumps_d = jumps_q + 4'd1;
      if (!jumped_q) begin
        jumped_d = 1'b1;
        first_d  = pos_inc;
      end
    end
  end

  assign rd_addr_o = pos_d[ADDR_W-1:0];

  assign put  = cmd_i.put_chr | cmd_i.put_dot;
  assign ch   = cmd_i.put_dot ? dnsd_pkg::DOT_CHAR : rd_data_i;
  assign keep = name_q < CntW'(NameCap);
  assign full = cnt_q == 4'(dnsd_pkg::CHUNK_CHARS);

  always_comb begin
    buf_d   = buf_q;
    cnt_d   = cnt_q;
    name_d  = name_q;
    trunc_d = trunc_q;
    valid_d = 1'b0;
    out_d   = out_q;
    if (cmd_i.init) begin
      buf_d   = '0;
      cnt_d   = '0;
      name_d  = '0;
      trunc_d = 1'b0;
    end else if (put) begin
      if (keep) begin
        name_d = name_q + CntW'(1);
        if (full) begin
          valid_d              = 1'b1;
          out_d.chunk          = buf_q;
          out_d.chunk_len      = cnt_q;
          out_d.last_chunk     = 1'b0;
          out_d.next_offset    = '0;
          out_d.name_truncated = 1'b0;
          buf_d                = '0;
          buf_d[0]             = ch;
          cnt_d                = 4'd1;
        end else begin
          buf_d[cnt_q[dnsd_pkg::CHUNK_IDX_W-1:0]] = ch;
          cnt_d = cnt_q + 4'd1;
        end
      end else begin
        trunc_d = 1'b1;
      end
    end
    if (cmd_i.emit_last) begin
      valid_d              = 1'b1;
      out_d.chunk          = buf_q;
      out_d.chunk_len      = cnt_q;
      out_d.last_chunk     = 1'b1;
      out_d.next_offset    = end_pos[12:0];
      out_d.name_truncated = trunc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      limit_q  <= '0;
      jumped_q <= 1'b0;
      jumps_q  <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
      name_q   <= '0;
      trunc_q  <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      limit_q  <= limit_d;
      jumped_q <= jumped_d;
      jumps_q  <= jumps_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
      name_q   <= name_d;
      trunc_q  <= trunc_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    hdr_q   <= hdr_d;
    buf_q   <= buf_d;
    out_q   <= out_d;
  end

  assign res_o       = out_q;
  assign res_valid_o = valid_q;

endmodule

### rtl/dns_name_decompressor_top.sv
// ----------------------------------------------------------------------------
// dns_name_decompressor_top
// DNS name decompressor: packet byte store plus label walker that emits the
// decoded name in 8-character chunks.
// ----------------------------------------------------------------------------
// Usage:
//   An input beat is taken when start is high and busy is low. A load beat
//   (command 0) writes byte_value at byte_address; busy stays low, so loads
//   can run back to back, and no result follows.
//   A decode beat (command 1) raises busy on the next cycle and walks the
//   stored name. The walker takes a header step for each header byte, a
//   header and a pointer step for each compression pointer, a character
//   step per label character, a dot step per label and a finish step. Each
//   full chunk leaves on res_o with res_valid_o high for one cycle; the last
//   chunk, with next_offset and name_truncated, appears the cycle busy drops.
//   The next beat can be taken in the cycle the last chunk is out.
//   Bytes are read through the store's registered read port, and no new
//   beat is taken while a decode is busy.
//   Results cannot be held off; each beat is valid for exactly one cycle.
//   Reset clears the walker and output strobe; packet store contents are
//   left undefined and must be loaded before use.
// ----------------------------------------------------------------------------
`include "dns_name_decompressor_top_defines.svh"

module dns_name_decompressor_top #(
  parameter int PKT_BYTES      = 4096,
  parameter int MAX_NAME_CHARS = 255
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  dnsd_pkg::dnsd_in_t  cmd_i,
  output dnsd_pkg::dnsd_out_t res_o,
  output logic                res_valid_o
);

  localparam int AddrW = $clog2(PKT_BYTES);
  localparam int PosW  = dnsd_pkg::POS_W;

  logic                take, load_we, dec_go;
  logic [AddrW-1:0]    rd_addr;
  logic [7:0]          rd_data;
  dnsd_pkg::dnsd_cmd_t cmd;
  dnsd_pkg::dnsd_sts_t sts;

  assign take    = start & ~busy;
  assign load_we = take && (cmd_i.command == dnsd_pkg::CMD_LOAD)
                   && (PosW'(cmd_i.byte_address) < PosW'(PKT_BYTES));
  assign dec_go  = take && (cmd_i.command == dnsd_pkg::CMD_DECODE);

  dnsd_store #(
    .DEPTH  (PKT_BYTES),
    .ADDR_W (AddrW)
  ) u_store (
    .clk_i (clk_i),
    .we_i  (load_we),
    .wa_i  (AddrW'(cmd_i.byte_address)),
    .wd_i  (cmd_i.byte_value),
    .ra_i  (rd_addr),
    .rd_o  (rd_data)
  );

  dnsd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (dec_go),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  dnsd_dp #(
    .PKT_BYTES      (PKT_BYTES),
    .MAX_NAME_CHARS (MAX_NAME_CHARS),
    .ADDR_W         (AddrW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .start_offset_i (cmd_i.start_offset),
    .pkt_len_i      (cmd_i.pkt_len),
    .rd_data_i      (rd_data),
    .rd_addr_o      (rd_addr),
    .res_o          (res_o),
    .res_valid_o    (res_valid_o)
  );

  `DNSD_ASSERT_NEXT(a_decode_busy, dec_go, busy, "decode accept did not raise busy")
  `DNSD_ASSERT_NEXT(a_mid_chunk_busy, res_valid_o && !res_o.last_chunk, busy,
                    "walk ended after a middle chunk")
  `DNSD_ASSERT_NOW(a_last_idle, res_valid_o && res_o.last_chunk, !busy,
                   "last chunk while still busy")
  `DNSD_ASSERT_NOW(a_mid_chunk_full, res_valid_o && !res_o.last_chunk,
                   res_o.chunk_len == 4'd8, "middle chunk not full")

endmodule

### dv/dns_name_decompressor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_name_decompressor_top_tb
// Self-checking bench for the DNS name decompressor. Packet bytes are loaded
// beat by beat and names are decoded from them: plain label runs, compressed
// names, pointer loops that exhaust the jump budget or the name cap, and
// broken encodings. A behavioral walk of the stored packet predicts every
// chunk beat, which is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module dns_name_decompressor_top_tb;

  localparam int PKT_BYTES      = 4096;
  localparam int MAX_NAME_CHARS = 255;
  localparam int NAME_BUF       = dnsd_pkg::MAX_RESULTS * dnsd_pkg::CHUNK_CHARS;
  localparam int NAME_CAP       = (MAX_NAME_CHARS < NAME_BUF) ? MAX_NAME_CHARS : NAME_BUF;
  localparam int RAND_ITEMS     = 450;
  localparam int IDLE_LIMIT     = 60000;
  localparam int DRAIN_CYCLES   = 64;

  // directed packet, byte 0 in the low byte
  localparam logic [8*14-1:0] DIR_PKT = {8'h05, 8'h3F, 8'hC0, 8'h09, 8'hC0, 8'h00, 8'hC0,
                                         8'h00, "a", 8'h01, "w", "w", "w", 8'h03};

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                start  = 1'b0;
  logic                busy;
  dnsd_pkg::dnsd_in_t  cmd_i  = '0;
  dnsd_pkg::dnsd_out_t res_o;
  logic                res_valid_o;

  dnsd_pkg::dnsd_in_t  pending_beats[$];
  dnsd_pkg::dnsd_out_t exp_chunks[$];
  logic [7:0]  pkt_mem [PKT_BYTES];
  int unsigned name_starts[$];
  int unsigned fill_mark = 0;
  int unsigned n_queued  = 0;
  int burst_left = 0, gap_left = 0, idle_cnt = 0, err_cnt = 0;
  int n_loads = 0, n_decodes = 0, n_chunks = 0, n_trunc = 0;

  dns_name_decompressor_top #(
    .PKT_BYTES     (PKT_BYTES),
    .MAX_NAME_CHARS(MAX_NAME_CHARS)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .cmd_i,
    .res_o,
    .res_valid_o
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------- stimulus

  task automatic queue_load(input int unsigned addr, input logic [7:0] val);
    logic [63:0]        rnd;
    dnsd_pkg::dnsd_in_t it;
    rnd = {$urandom, $urandom};
    it = rnd[$bits(dnsd_pkg::dnsd_in_t)-1:0];
    it.command      = dnsd_pkg::CMD_LOAD;
    it.byte_address = addr[11:0];
    it.byte_value   = val;
    pending_beats.push_back(it);
    n_queued++;
  endtask

  task automatic queue_decode(input int unsigned offs, input int unsigned tlen);
    logic [63:0]        rnd;
    dnsd_pkg::dnsd_in_t it;
    rnd = {$urandom, $urandom};
    it = rnd[$bits(dnsd_pkg::dnsd_in_t)-1:0];
    it.command      = dnsd_pkg::CMD_DECODE;
    it.start_offset = offs[11:0];
    it.pkt_len      = tlen[12:0];
    pending_beats.push_back(it);
    n_queued++;
  endtask

  function automatic logic [7:0] fill_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'h00;
    if (r < 40) return dnsd_pkg::PTR_MARK |
                       (($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 63)) : 8'h00);
    if (r < 70) return 8'($urandom_range(1, 12));
    return 8'($urandom);
  endfunction

  // keep [0, upto) written so no decode reads an unloaded byte
  task automatic grow_fill(input int unsigned upto);
    while (fill_mark < upto) begin
      queue_load(fill_mark, fill_byte());
      fill_mark++;
    end
  endtask

  task automatic write_name(input int unsigned at, input int unsigned plen);
    int unsigned p, len, n_lab, kind, tgt, l, i;
    p = at;
    kind = $urandom_range(0, 99);
    n_lab = (kind >= 85) ? 1 : $urandom_range(0, 4);
    for (l = 0; l < n_lab; l++) begin
      if (kind >= 85)
        len = $urandom_range(24, 40);
      else if ($urandom_range(0, 9) == 0)
        len = $urandom_range(13, 63);
      else
        len = $urandom_range(1, 12);
      if (p + len + 3 > plen) break;
      queue_load(p, 8'(len));
      p++;
      for (i = 0; i < len; i++) begin
        queue_load(p, ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(33, 126)));
        p++;
      end
    end
    if (kind >= 85)
      tgt = at;
    else if (kind >= 70 && name_starts.size() != 0)
      tgt = name_starts[$urandom_range(0, name_starts.size() - 1)];
    else if (kind >= 62)
      tgt = $urandom_range(0, 16383);
    else
      tgt = 16384;
    if (tgt < 16384) begin
      queue_load(p, dnsd_pkg::PTR_MARK | 8'(tgt >> 8));
      queue_load(p + 1, 8'(tgt));
    end else begin
      queue_load(p, 8'h00);
    end
    name_starts.push_back(at);
  endtask

  // --------------------------------------------------------------- predictor

  function automatic void predict_decode(input dnsd_pkg::dnsd_in_t it);
    logic [7:0]          name_chr [NAME_BUF];
    int unsigned         lim, pos, hop_cnt, resume, n_chr, n_res, b, i, k;
    bit                  jumped, trunc, done;
    dnsd_pkg::dnsd_out_t r;
    lim = (it.pkt_len > PKT_BYTES) ? PKT_BYTES : it.pkt_len;
    pos = it.start_offset;
    hop_cnt = 0;
    resume  = 0;
    n_chr   = 0;
    jumped  = 1'b0;
    trunc   = 1'b0;
    done    = 1'b0;
    while (!done && pos < lim) begin
      b = pkt_mem[pos];
      pos++;
      if (b == 0) begin
        done = 1'b1;
      end else if ((b & dnsd_pkg::PTR_MARK) == dnsd_pkg::PTR_MARK) begin
        if (pos >= lim) begin
          done = 1'b1;
        end else begin
          if (!jumped) resume = pos + 1;
          jumped = 1'b1;
          pos = ((b & dnsd_pkg::PTR_HI_MASK) << 8) | pkt_mem[pos];
          hop_cnt++;
          done = (hop_cnt > dnsd_pkg::MAX_JUMPS);
        end
      end else if (pos + b > lim) begin
        done = 1'b1;
      end else begin
        for (i = 0; i <= b; i++) begin
          if (n_chr < NAME_CAP) begin
            name_chr[n_chr] = (i < b) ? pkt_mem[pos + i] : dnsd_pkg::DOT_CHAR;
            n_chr++;
          end else begin
            trunc = 1'b1;
          end
        end
        pos += b;
      end
    end
    n_res = (n_chr == 0) ? 1 : (n_chr + dnsd_pkg::CHUNK_CHARS - 1) / dnsd_pkg::CHUNK_CHARS;
    for (k = 0; k < n_res; k++) begin
      r = '0;
      for (i = 0; i < dnsd_pkg::CHUNK_CHARS; i++) begin
        if (k * dnsd_pkg::CHUNK_CHARS + i < n_chr) begin
          r.chunk[8*i +: 8] = name_chr[k * dnsd_pkg::CHUNK_CHARS + i];
          r.chunk_len = r.chunk_len + 4'd1;
        end
      end
      if (k + 1 == n_res) begin
        r.last_chunk     = 1'b1;
        r.next_offset    = 13'(jumped ? resume : pos);
        r.name_truncated = trunc;
      end
      exp_chunks.push_back(r);
    end
  endfunction

  function automatic void check_field(input string fname, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // ------------------------------------------------------------------ driver

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        start <= 1'b1;
        cmd_i <= pending_beats.pop_front();
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ----------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    dnsd_pkg::dnsd_out_t exp_r;
    if (rst_ni) begin
      if (res_valid_o) begin
        if (exp_chunks.size() == 0) begin
          $error("chunk beat with nothing expected: chunk 0x%0h len %0d",
                 res_o.chunk, res_o.chunk_len);
          err_cnt++;
        end else begin
          exp_r = exp_chunks.pop_front();
          check_field("chunk", exp_r.chunk, res_o.chunk);
          check_field("chunk_len", 64'(exp_r.chunk_len), 64'(res_o.chunk_len));
          check_field("last_chunk", 64'(exp_r.last_chunk), 64'(res_o.last_chunk));
          check_field("next_offset", 64'(exp_r.next_offset), 64'(res_o.next_offset));
          check_field("name_truncated", 64'(exp_r.name_truncated), 64'(res_o.name_truncated));
          n_chunks++;
          if (exp_r.name_truncated) n_trunc++;
        end
      end
      if (start && !busy) begin
        if (cmd_i.command == dnsd_pkg::CMD_DECODE) begin
          predict_decode(cmd_i);
          n_decodes++;
        end else begin
          pkt_mem[cmd_i.byte_address] = cmd_i.byte_value;
          n_loads++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $error("no beat for %0d cycles", IDLE_LIMIT);
      $display("dns_name_decompressor_top_tb: FAIL");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // -------------------------------------------------------------------- main

  initial begin
    int unsigned s, t, sel, plen, i;

    // directed: plain name, pointer, self loop, zero byte, pointer in last
    // byte, pointer out of range, label past length, empty range, top address
    for (i = 0; i < 14; i++) queue_load(i, DIR_PKT[8*i +: 8]);
    fill_mark = 14;
    queue_load(PKT_BYTES - 1, 8'hFF);
    queue_decode(0, 14);
    queue_decode(7, 14);
    queue_decode(9, 14);
    queue_decode(6, 14);
    queue_decode(11, 12);
    queue_decode(11, 14);
    queue_decode(13, 14);
    queue_decode(0, 0);
    queue_decode(PKT_BYTES - 1, PKT_BYTES);
    queue_decode(PKT_BYTES - 1, 8191);

    while (n_queued < RAND_ITEMS) begin
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(201, 260) : $urandom_range(96, 200);
      grow_fill(plen);
      repeat ($urandom_range(1, 2)) write_name($urandom_range(0, plen / 2), plen);
      repeat ($urandom_range(6, 12)) begin
        sel = $urandom_range(0, 99);
        if (sel < 70)
          s = name_starts[$urandom_range(0, name_starts.size() - 1)];
        else if (sel < 85)
          s = $urandom_range(0, plen - 1);
        else
          s = $urandom_range(0, PKT_BYTES - 1);
        sel = $urandom_range(0, 99);
        if (sel < 70)
          t = plen;
        else if (sel < 85)
          t = $urandom_range(0, fill_mark);
        else
          t = fill_mark;
        queue_decode(s, t);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i); while (pending_beats.size() != 0 || start);
    while (exp_chunks.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d byte loads and %0d name decodes, %0d chunk beats checked,",
             n_loads, n_decodes, n_chunks);
    $display("%0d of the decoded names ran into the length cap", n_trunc);
    if (err_cnt == 0 && exp_chunks.size() == 0) begin
      $display("dns_name_decompressor_top_tb: PASS");
    end else begin
      $display("dns_name_decompressor_top_tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/dnsd_pkg.sv
rtl/dnsd_store.sv
rtl/dnsd_ctrl.sv
rtl/dnsd_dp.sv
rtl/dns_name_decompressor_top.sv
dv/dns_name_decompressor_top_tb.sv
